### sv/lca_pkg.sv
`timescale 1ns / 1ps
package lca_pkg;

  localparam int NODES    = 1024;
  localparam int LEVELS   = 12;
  localparam int NW       = $clog2(NODES);
  localparam int EW       = $clog2(2 * NODES);
  localparam int LW       = $clog2(LEVELS + 1);
  localparam int SPW      = NW + 1;
  localparam int CW       = 11;
  localparam int FW       = 3;
  localparam int EDGE_CAP = 2 * (NODES - 1);
  localparam int EDEPTH   = 2 * NODES;
  localparam int ADEPTH   = NODES * (2 ** LW);

  typedef enum logic [FW-1:0] {
    FN_START = 3'd0,
    FN_EDGE  = 3'd1,
    FN_BUILD = 3'd2,
    FN_QUERY = 3'd3,
    FN_ROOT  = 3'd4
  } func_e;

  typedef struct packed {
    logic          go;
    logic [FW-1:0] func;
    logic [NW-1:0] a;
    logic [NW-1:0] b;
  } cmd_t;

  typedef struct packed {
    logic          valid;
    logic [NW-1:0] node;
  } res_t;

  typedef struct packed {
    logic [EW-1:0] nxt;
    logic [NW-1:0] endn;
  } edge_t;

  typedef struct packed {
    logic [NW-1:0] node;
    logic [EW-1:0] cur;
  } stack_t;

endpackage

### sv/lca_ram.sv
`timescale 1ns / 1ps
module lca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/lca_core.sv
`timescale 1ns / 1ps
module lca_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lca_pkg::cmd_t           cmd_i,
  input  logic [lca_pkg::CW-1:0]  node_count_i,
  output logic                    busy_o,
  output lca_pkg::res_t           res_o,
  input  logic                    res_ready_i
);

  localparam int NW  = lca_pkg::NW;
  localparam int EW  = lca_pkg::EW;
  localparam int LW  = lca_pkg::LW;
  localparam int SPW = lca_pkg::SPW;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_E1, S_E2, S_E3, S_B0, S_BHEAD, S_VRD, S_VWR, S_BTOP,
    S_BEDGE, S_BCHK, S_BPOP, S_L0, S_L1, S_L2, S_LURD, S_LUD, S_LUC, S_LCHK,
    S_JA, S_JB, S_JC, S_FIN, S_FIN2, S_RES, S_RES2, S_OUT
  } state_e;

  state_e state_q;

  logic [NW-1:0]  clr_q, a_q, b_q, root_q, tos_node_q, v_q, mid_q;
  logic [EW-1:0]  fill_q, tos_cur_q;
  logic [SPW-1:0] sp_q;
  logic [LW-1:0]  k_q;
  logic [NW-1:0]  x_q, y_q, dx_q, dy_q, up_q, ux_q, r_q;
  logic [1:0]     call_q;
  logic [NW-1:0]  res_q  [3];
  logic [NW-1:0]  rdep_q [3];

  logic                  head_we;
  logic [NW-1:0]         head_wa, head_ra;
  logic [EW-1:0]         head_wd, head_rd;
  logic                  edge_we;
  logic [EW-1:0]         edge_wa, edge_ra;
  lca_pkg::edge_t        edge_wd, edge_rd;
  logic                  vis_we;
  logic [NW-1:0]         vis_wa, vis_ra;
  logic                  vis_wd, vis_rd;
  logic                  dep_we;
  logic [NW-1:0]         dep_wa, dep_ra, dep_wd, dep_rd;
  logic                  anc_we;
  logic [NW+LW-1:0]      anc_wa, anc_ra;
  logic [NW-1:0]         anc_wd, anc_rd;
  logic                  stk_we;
  logic [NW-1:0]         stk_wa, stk_ra;
  lca_pkg::stack_t       stk_wd, stk_rd;

  logic [NW:0]   n_eff;
  logic          edge_ok;
  logic [NW-1:0] sel_node;

  always_comb begin
    if (node_count_i == '0) begin
      n_eff = (NW + 1)'(1);
    end else if ((lca_pkg::CW + 1)'(node_count_i) > (lca_pkg::CW + 1)'(lca_pkg::NODES)) begin
      n_eff = (NW + 1)'(lca_pkg::NODES);
    end else begin
      n_eff = (NW + 1)'(node_count_i);
    end
  end

  assign edge_ok = ({1'b0, cmd_i.a} < n_eff) && ({1'b0, cmd_i.b} < n_eff) &&
                   ((EW + 1)'(fill_q) + (EW + 1)'(2) <= (EW + 1)'(lca_pkg::EDGE_CAP));

  always_comb begin
    if (rdep_q[0] >= rdep_q[1] && rdep_q[0] >= rdep_q[2]) begin
      sel_node = res_q[0];
    end else if (rdep_q[1] >= rdep_q[2]) begin
      sel_node = res_q[1];
    end else begin
      sel_node = res_q[2];
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_o.valid = (state_q == S_OUT);
  assign res_o.node  = sel_node;

  always_comb begin
    head_we = 1'b0; head_wa = '0; head_wd = '0; head_ra = '0;
    edge_we = 1'b0; edge_wa = '0; edge_wd = '0; edge_ra = '0;
    vis_we  = 1'b0; vis_wa  = '0; vis_wd  = 1'b0; vis_ra = '0;
    dep_we  = 1'b0; dep_wa  = '0; dep_wd  = '0; dep_ra  = '0;
    anc_we  = 1'b0; anc_wa  = '0; anc_wd  = '0; anc_ra  = '0;
    stk_we  = 1'b0; stk_wa  = '0; stk_wd  = '0; stk_ra  = '0;
    case (state_q)
      S_CLR: begin
        head_we = 1'b1; head_wa = clr_q;
        vis_we  = 1'b1; vis_wa  = clr_q;
      end
      S_E1: begin
        head_ra = a_q;
      end
      S_E2: begin
        edge_we = 1'b1; edge_wa = fill_q;
        edge_wd.nxt = head_rd; edge_wd.endn = b_q;
        head_we = 1'b1; head_wa = a_q; head_wd = fill_q + 1'b1;
        head_ra = b_q;
      end
      S_E3: begin
        edge_we = 1'b1; edge_wa = fill_q;
        edge_wd.nxt = (a_q == b_q) ? fill_q : head_rd; edge_wd.endn = a_q;
        head_we = 1'b1; head_wa = b_q; head_wd = fill_q + 1'b1;
      end
      S_B0: begin
        vis_we = 1'b1; vis_wd = 1'b1;
        dep_we = 1'b1;
        anc_we = 1'b1;
      end
      S_VRD: begin
        anc_ra = {mid_q, k_q - 1'b1};
      end
      S_VWR: begin
        anc_we = 1'b1; anc_wa = {v_q, k_q}; anc_wd = anc_rd;
      end
      S_BTOP: begin
        stk_ra = NW'(sp_q - SPW'(2));
        edge_ra = tos_cur_q - 1'b1;
      end
      S_BEDGE: begin
        vis_ra = edge_rd.endn;
        dep_ra = tos_node_q;
      end
      S_BCHK: begin
        if (!vis_rd && sp_q < SPW'(lca_pkg::NODES)) begin
          vis_we = 1'b1; vis_wa = v_q; vis_wd = 1'b1;
          dep_we = 1'b1; dep_wa = v_q; dep_wd = dep_rd + 1'b1;
          anc_we = 1'b1; anc_wa = {v_q, LW'(0)}; anc_wd = tos_node_q;
          stk_we = 1'b1; stk_wa = NW'(sp_q - SPW'(1));
          stk_wd.node = tos_node_q; stk_wd.cur = tos_cur_q;
          head_ra = v_q;
        end
      end
      S_L0:   dep_ra = x_q;
      S_L1:   dep_ra = y_q;
      S_LURD: anc_ra = {x_q, k_q};
      S_LUD:  dep_ra = anc_rd;
      S_JA:   anc_ra = {x_q, k_q};
      S_JB:   anc_ra = {y_q, k_q};
      S_FIN:  anc_ra = {x_q, LW'(0)};
      S_RES:  dep_ra = r_q;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      fill_q  <= '0;
      root_q  <= '0;
      sp_q    <= '0;
      k_q     <= '0;
      call_q  <= '0;
    end else begin
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == NW'(lca_pkg::NODES - 1)) begin
            fill_q  <= '0;
            root_q  <= '0;
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          a_q <= cmd_i.a;
          b_q <= cmd_i.b;
          if (cmd_i.go) begin
            case (lca_pkg::func_e'(cmd_i.func))
              lca_pkg::FN_START: begin
                clr_q   <= '0;
                state_q <= S_CLR;
              end
              lca_pkg::FN_EDGE: begin
                if (edge_ok) begin
                  state_q <= S_E1;
                end
              end
              lca_pkg::FN_BUILD: state_q <= S_B0;
              lca_pkg::FN_QUERY: begin
                x_q     <= cmd_i.a;
                y_q     <= cmd_i.b;
                call_q  <= '0;
                state_q <= S_L0;
              end
              lca_pkg::FN_ROOT: root_q <= cmd_i.a;
              default: begin
              end
            endcase
          end
        end
        S_E1: state_q <= S_E2;
        S_E2: begin
          fill_q  <= fill_q + 1'b1;
          state_q <= S_E3;
        end
        S_E3: begin
          fill_q  <= fill_q + 1'b1;
          state_q <= S_IDLE;
        end
        S_B0: begin
          v_q        <= '0;
          mid_q      <= '0;
          k_q        <= LW'(1);
          tos_node_q <= '0;
          sp_q       <= SPW'(1);
          state_q    <= S_BHEAD;
        end
        S_BHEAD: begin
          tos_cur_q <= head_rd;
          state_q   <= S_VRD;
        end
        S_VRD: begin
          state_q <= (k_q == LW'(lca_pkg::LEVELS)) ? S_BTOP : S_VWR;
        end
        S_VWR: begin
          mid_q   <= anc_rd;
          k_q     <= k_q + 1'b1;
          state_q <= S_VRD;
        end
        S_BTOP: begin
          if (sp_q == '0) begin
            state_q <= S_IDLE;
          end else if (tos_cur_q == '0) begin
            sp_q    <= sp_q - 1'b1;
            state_q <= (sp_q == SPW'(1)) ? S_IDLE : S_BPOP;
          end else begin
            state_q <= S_BEDGE;
          end
        end
        S_BPOP: begin
          tos_node_q <= stk_rd.node;
          tos_cur_q  <= stk_rd.cur;
          state_q    <= S_BTOP;
        end
        S_BEDGE: begin
          tos_cur_q <= edge_rd.nxt;
          v_q       <= edge_rd.endn;
          state_q   <= S_BCHK;
        end
        S_BCHK: begin
          if (!vis_rd && sp_q < SPW'(lca_pkg::NODES)) begin
            mid_q      <= tos_node_q;
            tos_node_q <= v_q;
            sp_q       <= sp_q + 1'b1;
            k_q        <= LW'(1);
            state_q    <= S_BHEAD;
          end else begin
            state_q <= S_BTOP;
          end
        end
        S_L0: state_q <= S_L1;
        S_L1: begin
          dx_q    <= dep_rd;
          state_q <= S_L2;
        end
        S_L2: begin
          if (dx_q < dep_rd) begin
            x_q  <= y_q;
            y_q  <= x_q;
            dy_q <= dx_q;
          end else begin
            dy_q <= dep_rd;
          end
          k_q     <= LW'(lca_pkg::LEVELS - 1);
          state_q <= S_LURD;
        end
        S_LURD: state_q <= S_LUD;
        S_LUD: begin
          up_q    <= anc_rd;
          state_q <= S_LUC;
        end
        S_LUC: begin
          if (dep_rd >= dy_q) begin
            x_q <= up_q;
          end
          if (k_q == '0) begin
            state_q <= S_LCHK;
          end else begin
            k_q     <= k_q - 1'b1;
            state_q <= S_LURD;
          end
        end
        S_LCHK: begin
          if (x_q == y_q) begin
            r_q     <= x_q;
            state_q <= S_RES;
          end else begin
            k_q     <= LW'(lca_pkg::LEVELS - 1);
            state_q <= S_JA;
          end
        end
        S_JA: state_q <= S_JB;
        S_JB: begin
          ux_q    <= anc_rd;
          state_q <= S_JC;
        end
        S_JC: begin
          if (ux_q != anc_rd) begin
            x_q <= ux_q;
            y_q <= anc_rd;
          end
          if (k_q == '0) begin
            state_q <= S_FIN;
          end else begin
            k_q     <= k_q - 1'b1;
            state_q <= S_JA;
          end
        end
        S_FIN: state_q <= S_FIN2;
        S_FIN2: begin
          r_q     <= anc_rd;
          state_q <= S_RES;
        end
        S_RES: state_q <= S_RES2;
        S_RES2: begin
          res_q[call_q]  <= r_q;
          rdep_q[call_q] <= dep_rd;
          x_q            <= root_q;
          y_q            <= (call_q == 2'd0) ? a_q : b_q;
          call_q         <= call_q + 1'b1;
          state_q        <= (call_q == 2'd2) ? S_OUT : S_L0;
        end
        S_OUT: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  lca_ram #(.WIDTH(EW), .DEPTH(lca_pkg::NODES)) u_head (
    .clk_i(clk_i), .we_i(head_we), .waddr_i(head_wa), .wdata_i(head_wd),
    .raddr_i(head_ra), .rdata_o(head_rd)
  );

  lca_ram #(.WIDTH(EW + NW), .DEPTH(lca_pkg::EDEPTH)) u_edge (
    .clk_i(clk_i), .we_i(edge_we), .waddr_i(edge_wa), .wdata_i(edge_wd),
    .raddr_i(edge_ra), .rdata_o(edge_rd)
  );

  lca_ram #(.WIDTH(1), .DEPTH(lca_pkg::NODES)) u_vis (
    .clk_i(clk_i), .we_i(vis_we), .waddr_i(vis_wa), .wdata_i(vis_wd),
    .raddr_i(vis_ra), .rdata_o(vis_rd)
  );

  lca_ram #(.WIDTH(NW), .DEPTH(lca_pkg::NODES)) u_depth (
    .clk_i(clk_i), .we_i(dep_we), .waddr_i(dep_wa), .wdata_i(dep_wd),
    .raddr_i(dep_ra), .rdata_o(dep_rd)
  );

  lca_ram #(.WIDTH(NW), .DEPTH(lca_pkg::ADEPTH)) u_anc (
    .clk_i(clk_i), .we_i(anc_we), .waddr_i(anc_wa), .wdata_i(anc_wd),
    .raddr_i(anc_ra), .rdata_o(anc_rd)
  );

  lca_ram #(.WIDTH(NW + EW), .DEPTH(lca_pkg::NODES)) u_stack (
    .clk_i(clk_i), .we_i(stk_we), .waddr_i(stk_wa), .wdata_i(stk_wd),
    .raddr_i(stk_ra), .rdata_o(stk_rd)
  );

endmodule

### sv/rerooted_tree_lca_engine_top.sv
`timescale 1ns / 1ps
// Rerooted LCA engine: builds a tree from edge beats, then answers LCA
// queries under a movable root.
// Input channel (in_valid_i / in_stall_o): func_i, node_a_i, node_b_i.
// func 0 starts a tree, 1 adds an edge, 2 builds the tables, 3 queries,
// 4 sets the root; other codes are dropped.
// Output channel (out_valid_o / out_stall_i): lca_node_o, one beat per
// query only. Config channel (cfg_valid_i / cfg_ready_o): node count.
// One item at a time, timed by a sequencer over registered-read RAMs:
// set root, unused codes and a dropped edge are taken in the idle state,
// an edge writes both directed edge records, a start runs a clear sweep
// of the edge heads and visited marks, a build walks every reached node
// and edge end, and a query makes three walks; the result of a query
// goes into the output register before its beat is offered.
// After reset the same clear sweep runs with in_stall_o
// high. A stalled output beat holds in its register; a finished query
// waits in the engine, which takes no new beat until the result is moved.
module rerooted_tree_lca_engine_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [lca_pkg::FW-1:0]       func_i,
  input  logic [lca_pkg::NW-1:0]       node_a_i,
  input  logic [lca_pkg::NW-1:0]       node_b_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [lca_pkg::NW-1:0]       lca_node_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lca_pkg::CW-1:0]       cfg_data_i
);

  lca_pkg::cmd_t          cmd;
  lca_pkg::res_t          core_res;
  logic                   core_busy;
  logic                   res_ready;
  logic [lca_pkg::CW-1:0] node_count_q;
  logic                   out_valid_q;
  logic [lca_pkg::NW-1:0] out_node_q;

  assign in_stall_o  = core_busy;
  assign cfg_ready_o = 1'b1;
  assign cmd.go      = in_valid_i && !core_busy;
  assign cmd.func    = func_i;
  assign cmd.a       = node_a_i;
  assign cmd.b       = node_b_i;
  assign res_ready   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign lca_node_o  = out_node_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= lca_pkg::CW'(1);
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        node_count_q <= cfg_data_i;
      end
      if (res_ready) begin
        out_valid_q <= core_res.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && core_res.valid) begin
      out_node_q <= core_res.node;
    end
  end

  lca_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .node_count_i (node_count_q),
    .busy_o       (core_busy),
    .res_o        (core_res),
    .res_ready_i  (res_ready)
  );

`ifndef SYNTHESIS
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && func_i == lca_pkg::FN_QUERY |=> in_stall_o)
    else $error("query beat did not occupy the engine");

  a_res_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_res.valid && res_ready |=> out_valid_o)
    else $error("finished query not moved to the output register");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_res.valid && !res_ready |=> core_res.valid && $stable(core_res.node))
    else $error("engine dropped a result while the output was full");

  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_res.valid |-> in_stall_o)
    else $error("engine took a beat while holding a result");
`endif

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int FN_TOP = 7;

  logic                   clk = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [lca_pkg::FW-1:0] func_i = '0;
  logic [lca_pkg::NW-1:0] node_a_i = '0;
  logic [lca_pkg::NW-1:0] node_b_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [lca_pkg::NW-1:0] lca_node_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [lca_pkg::CW-1:0] cfg_data_i = '0;

  rerooted_tree_lca_engine_top u_top (
    .clk_i(clk), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .func_i(func_i), .node_a_i(node_a_i), .node_b_i(node_b_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .lca_node_o(lca_node_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  // tree model state
  logic [lca_pkg::CW-1:0] count_reg = 11'd1;
  int head_of[lca_pkg::NODES];
  int link_next[lca_pkg::EDEPTH];
  int link_end[lca_pkg::EDEPTH];
  int link_fill = 0;
  bit seen[lca_pkg::NODES];
  int depth_of[lca_pkg::NODES];
  int up_tab[lca_pkg::NODES][lca_pkg::LEVELS];
  bit filled[lca_pkg::NODES];
  int filled_list[$];
  int walk_node[lca_pkg::NODES];
  int walk_cur[lca_pkg::NODES];
  int root_node = 0;

  logic [lca_pkg::NW-1:0] lca_expected_q[$];
  int errors = 0;
  int items_sent = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int rx_hold_len = 0;
  int rx_hold_req = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int eff_count();
    if (count_reg == 0) return 1;
    if (count_reg > lca_pkg::NODES) return lca_pkg::NODES;
    return count_reg;
  endfunction

  function automatic void mark_node(int v, int par, int d);
    int mid;
    seen[v] = 1'b1;
    depth_of[v] = d;
    up_tab[v][0] = par;
    for (int k = 1; k < lca_pkg::LEVELS; k++) begin
      mid = up_tab[v][k-1];
      up_tab[v][k] = up_tab[mid][k-1];
    end
    if (!filled[v]) begin
      filled[v] = 1'b1;
      filled_list = {filled_list, v};
    end
  endfunction

  function automatic void walk_tree();
    int sp, u, cur, e, v;
    mark_node(0, 0, 0);
    walk_node[0] = 0;
    walk_cur[0] = head_of[0];
    sp = 1;
    while (sp > 0) begin
      u = walk_node[sp-1];
      cur = walk_cur[sp-1];
      if (cur == 0) begin
        sp--;
      end else begin
        e = cur - 1;
        walk_cur[sp-1] = link_next[e];
        v = link_end[e];
        if (!seen[v] && sp < lca_pkg::NODES) begin
          mark_node(v, u, depth_of[u] + 1);
          walk_node[sp] = v;
          walk_cur[sp] = head_of[v];
          sp++;
        end
      end
    end
  endfunction

  function automatic int lca_zero(int x, int y);
    int t, ux, uy;
    if (depth_of[x] < depth_of[y]) begin
      t = x; x = y; y = t;
    end
    for (int k = lca_pkg::LEVELS - 1; k >= 0; k--) begin
      if (depth_of[up_tab[x][k]] >= depth_of[y]) x = up_tab[x][k];
    end
    if (x == y) return x;
    for (int k = lca_pkg::LEVELS - 1; k >= 0; k--) begin
      ux = up_tab[x][k];
      uy = up_tab[y][k];
      if (ux != uy) begin
        x = ux; y = uy;
      end
    end
    return up_tab[x][0];
  endfunction

  function automatic void add_link(int from, int to);
    link_end[link_fill] = to;
    link_next[link_fill] = head_of[from];
    head_of[from] = link_fill + 1;
    link_fill++;
  endfunction

  function automatic void apply_item(int f, int a, int b);
    int n, x, y, z, res;
    case (f)
      lca_pkg::FN_START: begin
        foreach (head_of[i]) head_of[i] = 0;
        foreach (seen[i]) seen[i] = 1'b0;
        link_fill = 0;
        root_node = 0;
      end
      lca_pkg::FN_EDGE: begin
        n = eff_count();
        if (a < n && b < n && link_fill + 2 <= lca_pkg::EDGE_CAP) begin
          add_link(a, b);
          add_link(b, a);
        end
      end
      lca_pkg::FN_BUILD: walk_tree();
      lca_pkg::FN_QUERY: begin
        x = lca_zero(a, b);
        y = lca_zero(root_node, a);
        z = lca_zero(root_node, b);
        if (depth_of[x] >= depth_of[y] && depth_of[x] >= depth_of[z]) res = x;
        else if (depth_of[y] >= depth_of[z]) res = y;
        else res = z;
        lca_expected_q = {lca_expected_q, lca_pkg::NW'(res)};
      end
      lca_pkg::FN_ROOT: root_node = a;
      default: ;
    endcase
  endfunction

  function automatic int tx_gap();
    int r;
    if (tx_quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(int f, int a, int b);
    int gap;
    bit ok;
    gap = tx_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid_i <= 1'b1;
    func_i <= lca_pkg::FW'(f);
    node_a_i <= lca_pkg::NW'(a);
    node_b_i <= lca_pkg::NW'(b);
    do begin
      @(negedge clk);
      ok = !in_stall_o;
      @(posedge clk);
    end while (!ok);
    apply_item(f, a, b);
    items_sent++;
  endtask

  task automatic drop_valid();
    in_valid_i <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (lca_expected_q.size() > 0) @(posedge clk);
  endtask

  // bring the block to idle; if 0 and root are built, a query shows it done
  task automatic settle();
    drop_valid();
    drain_results();
    if (filled[0] && filled[root_node]) begin
      send_item(lca_pkg::FN_QUERY, 0, 0);
      drop_valid();
      drain_results();
    end else begin
      repeat (lca_pkg::NODES + 200) @(posedge clk);
    end
  endtask

  task automatic write_count(int value);
    bit ok;
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= lca_pkg::CW'(value);
    do begin
      @(negedge clk);
      ok = cfg_ready_o;
      @(posedge clk);
    end while (!ok);
    count_reg = lca_pkg::CW'(value);
    cfg_valid_i <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int pick_node();
    int v;
    if ($urandom_range(0, 3) != 0) begin
      repeat (8) begin
        v = $urandom_range(0, eff_count() - 1);
        if (filled[v]) return v;
      end
    end
    return filled_list[$urandom_range(0, filled_list.size() - 1)];
  endfunction

  task automatic send_tree(int n);
    int order[];
    int t, j;
    order = new[n];
    foreach (order[i]) order[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i]; order[i] = order[j]; order[j] = t;
    end
    for (int i = 1; i < n; i++) begin
      j = order[$urandom_range(0, i - 1)];
      if ($urandom_range(0, 1)) send_item(lca_pkg::FN_EDGE, order[i], j);
      else send_item(lca_pkg::FN_EDGE, j, order[i]);
    end
  endtask

  task automatic send_queries(int q);
    int r;
    repeat (q) begin
      r = $urandom_range(0, 99);
      if (r < 80) send_item(lca_pkg::FN_QUERY, pick_node(), pick_node());
      else if (r < 95) send_item(lca_pkg::FN_ROOT, pick_node(),
                                 $urandom_range(0, lca_pkg::NODES - 1));
      else send_item($urandom_range(lca_pkg::FN_ROOT + 1, FN_TOP),
                     $urandom_range(0, lca_pkg::NODES - 1),
                     $urandom_range(0, lca_pkg::NODES - 1));
    end
  endtask

  task automatic test_directed();
    write_count(5);
    send_item(lca_pkg::FN_START, 0, 0);
    send_item(lca_pkg::FN_EDGE, 0, 1);
    send_item(lca_pkg::FN_EDGE, 1, 2);
    send_item(lca_pkg::FN_EDGE, 3, 1);
    send_item(lca_pkg::FN_EDGE, 3, 4);
    send_item(lca_pkg::FN_EDGE, 5, 0);
    send_item(lca_pkg::FN_EDGE, 2, lca_pkg::NODES - 1);
    for (int f = lca_pkg::FN_ROOT + 1; f <= FN_TOP; f++)
      send_item(f, lca_pkg::NODES - 1, lca_pkg::NODES - 1);
    send_item(lca_pkg::FN_BUILD, 0, 0);
    send_item(lca_pkg::FN_QUERY, 2, 4);
    send_item(lca_pkg::FN_QUERY, 0, 0);
    send_item(lca_pkg::FN_QUERY, 4, 4);
    send_item(lca_pkg::FN_ROOT, 4, 0);
    send_item(lca_pkg::FN_QUERY, 2, 0);
    send_item(lca_pkg::FN_QUERY, 1, 2);
    send_item(lca_pkg::FN_ROOT, 2, lca_pkg::NODES - 1);
    send_item(lca_pkg::FN_QUERY, 4, 0);
    send_item(lca_pkg::FN_EDGE, 4, 2);
    send_item(lca_pkg::FN_BUILD, 0, 0);
    send_item(lca_pkg::FN_QUERY, 3, 2);
    send_item(lca_pkg::FN_ROOT, 0, 0);
    send_item(lca_pkg::FN_QUERY, 4, 2);
  endtask

  task automatic test_count_extremes();
    write_count(0);
    send_item(lca_pkg::FN_START, 0, 0);
    send_item(lca_pkg::FN_EDGE, 0, 1);
    send_item(lca_pkg::FN_BUILD, 0, 0);
    send_item(lca_pkg::FN_QUERY, 0, 0);
    write_count((1 << lca_pkg::CW) - 1);
    send_item(lca_pkg::FN_START, 0, 0);
    send_item(lca_pkg::FN_EDGE, 0, lca_pkg::NODES - 1);
    send_item(lca_pkg::FN_EDGE, lca_pkg::NODES - 1, 682);
    send_item(lca_pkg::FN_EDGE, 341, 682);
    send_item(lca_pkg::FN_BUILD, 0, 0);
    send_queries(10);
  endtask

  task automatic test_full_store();
    write_count(lca_pkg::NODES);
    send_item(lca_pkg::FN_START, 0, 0);
    send_tree(lca_pkg::NODES);
    repeat (3) send_item(lca_pkg::FN_EDGE, $urandom_range(0, lca_pkg::NODES - 1),
                         $urandom_range(0, lca_pkg::NODES - 1));
    send_item(lca_pkg::FN_BUILD, 0, 0);
    send_queries(60);
  endtask

  task automatic test_backpressure();
    settle();
    tx_quiet = 1'b1;
    rx_hold_len = 800;
    rx_hold_req++;
    repeat (20) send_item(lca_pkg::FN_QUERY, pick_node(), pick_node());
    tx_quiet = 1'b0;
    settle();
  endtask

  task automatic test_random_trees();
    int n, r;
    while (items_sent < 1850) begin
      r = $urandom_range(0, 99);
      n = (r < 75) ? $urandom_range(2, 40) : (r < 97) ? $urandom_range(41, 200) :
          $urandom_range(201, lca_pkg::NODES);
      write_count(n);
      tx_quiet = ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
      send_item(lca_pkg::FN_START, 0, 0);
      send_tree(n);
      if ($urandom_range(0, 3) == 0)
        send_item(lca_pkg::FN_EDGE, $urandom_range(n, lca_pkg::NODES - 1),
                  $urandom_range(0, lca_pkg::NODES - 1));
      send_item(lca_pkg::FN_BUILD, 0, 0);
      send_queries($urandom_range(20, 70));
      if ($urandom_range(0, 3) == 0) begin
        send_item(lca_pkg::FN_EDGE, $urandom_range(0, n - 1), $urandom_range(0, n - 1));
        send_item(lca_pkg::FN_BUILD, 0, 0);
        send_queries($urandom_range(5, 20));
      end
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin
    int hold_left, hold_seen, run_left;
    hold_left = 0;
    hold_seen = 0;
    run_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (rx_hold_req != hold_seen) begin
        hold_seen = rx_hold_req;
        hold_left = rx_hold_len - 1;
        out_stall_i <= 1'b1;
      end else if (run_left > 0) begin
        out_stall_i <= 1'b1;
        run_left--;
      end else if (!rx_quiet && $urandom_range(0, 99) < 30) begin
        out_stall_i <= 1'b1;
        run_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (lca_expected_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual lca_node %0d", $time, lca_node_o);
        errors++;
      end else if (lca_node_o !== lca_expected_q[0]) begin
        $display("%0t: lca_node expected %0d, actual %0d", $time, lca_expected_q[0],
                 lca_node_o);
        errors++;
        void'(lca_expected_q.pop_front());
      end else begin
        void'(lca_expected_q.pop_front());
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_directed();
    test_count_extremes();
    test_backpressure();
    test_full_store();
    test_random_trees();
    drop_valid();
    drain_results();
    repeat (500) @(posedge clk);
    if (errors == 0 && lca_expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
sv/lca_pkg.sv
sv/lca_ram.sv
sv/lca_core.sv
sv/rerooted_tree_lca_engine_top.sv
tb/sv/tb.sv
